// File: hdl/assert_macros.svh
// Assertion macros used by the counting semaphore RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/csq_pkg.sv
// Package for the counting semaphore block: field widths, operation and status codes,
// and the default sizes of the semaphore table. Depends on nothing.
`default_nettype none

package csq_pkg;

    localparam int FUNC_W      = 2;
    localparam int SEM_INDEX_W = 6;
    localparam int INIT_W      = 15;
    localparam int TASK_ID_W   = 8;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 16;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;

    localparam int SLOTS_DEFAULT      = 64;
    localparam int WAIT_DEPTH_DEFAULT = 8;
    localparam int TASK_BITS_DEFAULT  = 8;

    localparam int STATE_WORD_W_DEFAULT = 1 + COUNT_W + 2 * $clog2(WAIT_DEPTH_DEFAULT)
        + $clog2(WAIT_DEPTH_DEFAULT + 1) + WAIT_DEPTH_DEFAULT * TASK_BITS_DEFAULT;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_OPEN   = 2'd0,
        FUNC_WAIT   = 2'd1,
        FUNC_POST   = 2'd2,
        FUNC_UNLINK = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_INVALID    = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_QUEUE_FULL = 2'd3
    } status_t;

endpackage

`default_nettype wire

// File: hdl/csq_state_ram.sv
// Per-slot state memory: one write and one registered read a cycle, with the
// last write forwarded to the read data. Depends on csq_pkg for default sizes.
`default_nettype none

module csq_state_ram #(
    parameter int DEPTH  = csq_pkg::SLOTS_DEFAULT,
    parameter int WORD_W = csq_pkg::STATE_WORD_W_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire logic [WORD_W-1:0]         wr_data,
    output logic      [WORD_W-1:0]         rd_data
);

    localparam int ADDR_W = $clog2(DEPTH);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [WORD_W-1:0] fwd_data_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic              fwd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (wr_en)
        begin
            fwd_data_reg <= wr_data;
            fwd_addr_reg <= wr_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    // The most recent write may have landed at the same edge as the read.
    assign rd_data = (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg)) ? fwd_data_reg
                                                                      : rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/counting_semaphore_wait_queue.sv
// Top level of the counting semaphore table with per-slot FIFO wait queues.
// Depends on csq_pkg, csq_state_ram and assert_macros.svh.
//
// Usage: one request channel (func, sem_index, init_value, task_id with in_valid and
// in_stall) and one response channel (status, slot, blocked, woken_valid, woken_task
// with out_valid and out_stall). A transaction completes at a rising edge where valid
// is high and stall is low. Every request yields exactly one response, in order.
// A request accepted at one edge is registered together with its slot's state word;
// its response is loaded once the response register is empty or being drained.
// Throughput is one request per cycle while out_stall is low, set by the single read
// and single write port of the state memory; back-to-back requests to the same slot
// are served by forwarding the last write.
// When the receiver stalls, the response register holds its transaction and one more
// request may sit in the input register; in_stall rises only when both are full.
// Reset clears the slot allocation pointer and the pipeline valid flags; no clearing
// pass over the state memory is needed, as a slot is only read after open has written
// it. Freed slots are never reused.
`default_nettype none

`include "assert_macros.svh"

module counting_semaphore_wait_queue #(
    parameter int SLOTS      = csq_pkg::SLOTS_DEFAULT,
    parameter int WAIT_DEPTH = csq_pkg::WAIT_DEPTH_DEFAULT,
    parameter int TASK_BITS  = csq_pkg::TASK_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [csq_pkg::FUNC_W-1:0]      func,
    input  wire logic [csq_pkg::SEM_INDEX_W-1:0] sem_index,
    input  wire logic [csq_pkg::INIT_W-1:0]      init_value,
    input  wire logic [csq_pkg::TASK_ID_W-1:0]   task_id,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [csq_pkg::STATUS_W-1:0]         status,
    output logic [csq_pkg::SEM_INDEX_W-1:0]      slot,
    output logic                                 blocked,
    output logic                                 woken_valid,
    output logic [csq_pkg::TASK_ID_W-1:0]        woken_task
);

    import csq_pkg::*;

    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int NS_W      = $clog2(SLOTS + 1);
    localparam int HB        = $clog2(WAIT_DEPTH);
    localparam int FB        = $clog2(WAIT_DEPTH + 1);
    localparam int ROW_W     = WAIT_DEPTH * TASK_BITS;
    localparam int FILL_LO   = ROW_W;
    localparam int TAIL_LO   = FILL_LO + FB;
    localparam int HEAD_LO   = TAIL_LO + HB;
    localparam int CNT_LO    = HEAD_LO + HB;
    localparam int ALIVE_BIT = CNT_LO + COUNT_W;
    localparam int WORD_W    = ALIVE_BIT + 1;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [FUNC_W-1:0]          s1_func_reg;
    logic [SEM_INDEX_W-1:0]     s1_index_reg;
    logic [INIT_W-1:0]          s1_init_reg;
    logic [TASK_BITS-1:0]       s1_task_reg;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [STATUS_W-1:0]        status_reg;
    logic [SEM_INDEX_W-1:0]     slot_reg;
    logic                       blocked_reg;
    logic                       woken_valid_reg;
    logic [TASK_ID_W-1:0]       woken_task_reg;

    logic [NS_W-1:0]            next_slot_reg;
    logic [NS_W-1:0]            next_slot_next;

    logic                       accept;
    logic                       fire;
    logic [31:0]                in_idx_wide;
    logic [31:0]                task_wide;
    logic [SLOT_BITS-1:0]       rd_addr;

    logic [WORD_W-1:0]          cur_word;
    logic                       wr_en;
    logic [SLOT_BITS-1:0]       wr_addr;
    logic [WORD_W-1:0]          wr_word;

    status_t                    res_status;
    logic [SEM_INDEX_W-1:0]     res_slot;
    logic                       res_blocked;
    logic                       res_woken_valid;
    logic [TASK_ID_W-1:0]       res_woken_task;

    assign in_stall    = s1_valid_reg && out_valid_reg && out_stall;
    assign accept      = in_valid && !in_stall;
    assign fire        = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_idx_wide = 32'(sem_index);
    assign task_wide   = 32'(task_id);
    assign rd_addr     = in_idx_wide[SLOT_BITS-1:0];

    csq_state_ram #(
        .DEPTH  (SLOTS),
        .WORD_W (WORD_W)
    ) u_state_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_data (cur_word)
    );

    always_comb
    begin
        logic [31:0]               idx_wide;
        logic [31:0]               ns_wide;
        logic [31:0]               entry_wide;
        logic [SLOT_BITS-1:0]      idx_addr;
        logic                      slot_ok;
        logic                      cur_alive;
        logic signed [COUNT_W-1:0] cur_count;
        logic signed [COUNT_W-1:0] new_count;
        logic [HB-1:0]             cur_head;
        logic [HB-1:0]             cur_tail;
        logic [FB-1:0]             cur_fill;
        logic [ROW_W-1:0]          cur_row;
        logic [HB-1:0]             head_inc;
        logic [HB-1:0]             tail_inc;
        logic [TASK_BITS-1:0]      head_entry;
        logic [ROW_W-1:0]          row_next;

        idx_wide   = 32'(s1_index_reg);
        ns_wide    = 32'(next_slot_reg);
        idx_addr   = idx_wide[SLOT_BITS-1:0];
        cur_alive  = cur_word[ALIVE_BIT];
        cur_count  = signed'(cur_word[CNT_LO +: COUNT_W]);
        cur_head   = cur_word[HEAD_LO +: HB];
        cur_tail   = cur_word[TAIL_LO +: HB];
        cur_fill   = cur_word[FILL_LO +: FB];
        cur_row    = cur_word[ROW_W-1:0];
        head_inc   = (32'(cur_head) == WAIT_DEPTH - 1) ? '0 : HB'(cur_head + HB'(1));
        tail_inc   = (32'(cur_tail) == WAIT_DEPTH - 1) ? '0 : HB'(cur_tail + HB'(1));
        head_entry = cur_row[cur_head * TASK_BITS +: TASK_BITS];
        entry_wide = 32'(head_entry);
        row_next   = cur_row;
        for (int i = 0; i < WAIT_DEPTH; i++)
        begin
            if (HB'(i) == cur_tail)
            begin
                row_next[i * TASK_BITS +: TASK_BITS] = s1_task_reg;
            end
        end
        slot_ok = (idx_wide < 32'(SLOTS)) && (idx_wide < ns_wide) && cur_alive;

        res_status      = ST_OK;
        res_slot        = s1_index_reg;
        res_blocked     = 1'b0;
        res_woken_valid = 1'b0;
        res_woken_task  = '0;
        next_slot_next  = next_slot_reg;
        wr_addr         = idx_addr;
        wr_word         = cur_word;
        new_count       = cur_count;

        if (s1_func_reg == FUNC_OPEN)
        begin
            if (ns_wide >= 32'(SLOTS))
            begin
                res_status = ST_TABLE_FULL;
                res_slot   = '0;
            end
            else
            begin
                res_slot       = ns_wide[SEM_INDEX_W-1:0];
                wr_addr        = ns_wide[SLOT_BITS-1:0];
                wr_word        = {1'b1, COUNT_W'(s1_init_reg), HB'(0), HB'(0), FB'(0),
                                  cur_row};
                next_slot_next = NS_W'(next_slot_reg + NS_W'(1));
            end
        end
        else if (!slot_ok)
        begin
            res_status = ST_INVALID;
        end
        else
        begin
            case (s1_func_reg)
                FUNC_WAIT:
                begin
                    new_count = cur_count - 16'sd1;
                    if (new_count[COUNT_W-1])
                    begin
                        if (32'(cur_fill) >= WAIT_DEPTH)
                        begin
                            res_status = ST_QUEUE_FULL;
                        end
                        else
                        begin
                            res_blocked = 1'b1;
                            wr_word     = {1'b1, new_count, cur_head, tail_inc,
                                           FB'(cur_fill + FB'(1)), row_next};
                        end
                    end
                    else
                    begin
                        wr_word = {1'b1, new_count, cur_head, cur_tail, cur_fill, cur_row};
                    end
                end
                FUNC_POST:
                begin
                    if (cur_count != COUNT_MAX)
                    begin
                        new_count = cur_count + 16'sd1;
                    end
                    if ((new_count[COUNT_W-1] || (new_count == '0)) && (cur_fill != '0))
                    begin
                        res_woken_valid = 1'b1;
                        res_woken_task  = entry_wide[TASK_ID_W-1:0];
                        wr_word         = {1'b1, new_count, head_inc, cur_tail,
                                           FB'(cur_fill - FB'(1)), cur_row};
                    end
                    else
                    begin
                        wr_word = {1'b1, new_count, cur_head, cur_tail, cur_fill, cur_row};
                    end
                end
                default:
                begin
                    wr_word = {1'b0, cur_count, HB'(0), HB'(0), FB'(0), cur_row};
                end
            endcase
        end

        wr_en = fire && (res_status == ST_OK);
        if (!fire)
        begin
            next_slot_next = next_slot_reg;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            next_slot_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            next_slot_reg <= next_slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg  <= func;
            s1_index_reg <= sem_index;
            s1_init_reg  <= init_value;
            s1_task_reg  <= task_wide[TASK_BITS-1:0];
        end
        if (fire)
        begin
            status_reg      <= res_status;
            slot_reg        <= res_slot;
            blocked_reg     <= res_blocked;
            woken_valid_reg <= res_woken_valid;
            woken_task_reg  <= res_woken_task;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign blocked     = blocked_reg;
    assign woken_valid = woken_valid_reg;
    assign woken_task  = woken_task_reg;

    `ASSERT_IMPLIES(a_wake_excludes_block, clk, rst_n, out_valid_reg, !(blocked_reg && woken_valid_reg), "A response both blocks and wakes a task.")
    `ASSERT_IMPLIES(a_wake_only_when_ok, clk, rst_n, out_valid_reg && woken_valid_reg, status_reg == ST_OK, "A task was woken by a failed transaction.")
    `ASSERT_ALWAYS(a_next_slot_bound, clk, rst_n, 32'(next_slot_reg) <= SLOTS, "Slot allocation pointer ran past the table.")
    `ASSERT_NEXT(a_fire_gives_result, clk, rst_n, fire, out_valid_reg, "A processed request produced no response.")

endmodule

`default_nettype wire
